FILE: rtl/keyed_base64_payload_decoder_unit_defines.svh
`ifndef KEYED_BASE64_PAYLOAD_DECODER_UNIT_DEFINES_SVH
`define KEYED_BASE64_PAYLOAD_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KB64_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define KB64_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/kb64_pkg.sv
`timescale 1ns / 1ps

package kb64_pkg;

	localparam int MAX_KEY_LENGTH_DEF = 8;
	localparam int QUEUE_DEPTH_DEF    = 4;

	localparam int KEY_BYTES_W  = 64;
	localparam int KEY_LENGTH_W = 4;
	localparam int CFG_ADDR_W   = 1;

	// register indexes of the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_BYTES  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH = 1'b1;

	// reset key is "payload", first character in the low byte
	localparam logic [KEY_BYTES_W-1:0]  KEY_BYTES_RST  = 64'd28254628860223856;
	localparam logic [KEY_LENGTH_W-1:0] KEY_LENGTH_RST = 4'd7;

	localparam logic [7:0] CHAR_QUOTE = 8'h22;

	// one queue entry: a full 24-bit group or an end marker
	typedef struct packed {
		logic        is_end;
		logic [23:0] group;
	} kb64_cmd_t;

	// base64 symbol lookup: bit 6 is valid, bits 5..0 the value
	function automatic logic [6:0] sym_decode(logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c inside {[8'h41:8'h5A]}) begin          // 'A'..'Z'
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin // 'a'..'z'
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c inside {[8'h30:8'h39]}) begin // '0'..'9'
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin               // '+'
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin               // '/'
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

FILE: rtl/keyed_base64_payload_decoder_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata in_byte, tlast end_of_input,
//                                           tuser start_of_file
// m_axis    out  m_axis_tvalid/tready       tdata out_byte, tuser is_end, tlast last
// cfg       in   cfg_we (no wait)           cfg_addr index, cfg_wdata value
//
// Input takes an item per cycle while the queue has room; front state is registered.
// A decoded group leaves as three items, an end marker as one.
// The back's byte stepper sets one item per cycle while ready and work is queued.
// Front and back are parted by a QUEUE_DEPTH-entry queue; s_axis_tready drops
// only while the queue is full, so output stalls reach the input after that.
// Reset clears control state and loads the key registers with "payload", 7.
`include "keyed_base64_payload_decoder_unit_defines.svh"

module keyed_base64_payload_decoder_unit
	import kb64_pkg::*;
#(
	parameter int MAX_KEY_LENGTH = MAX_KEY_LENGTH_DEF,
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] in_byte
	input  logic                   s_axis_tlast,  // end_of_input
	input  logic                   s_axis_tuser,  // [0] start_of_file
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [7:0]             m_axis_tdata,  // [7:0] out_byte
	output logic                   m_axis_tlast,  // last
	output logic                   m_axis_tuser,  // [0] is_end
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [KEY_BYTES_W-1:0] cfg_wdata
);

	logic [KEY_BYTES_W-1:0]  key_bytes_q;
	logic [KEY_LENGTH_W-1:0] key_length_q;
	logic                    in_hs;
	logic                    q_push, q_pop, q_valid, q_full;
	kb64_cmd_t               wr_cmd, rd_cmd;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q  <= KEY_BYTES_RST;
			key_length_q <= KEY_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KEY_BYTES:  key_bytes_q  <= cfg_wdata;
				REG_KEY_LENGTH: key_length_q <= cfg_wdata[KEY_LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !q_full;
	assign in_hs         = s_axis_tvalid && s_axis_tready;

	kb64_front #(
		.MAX_KEY_LENGTH(MAX_KEY_LENGTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_hs),
		.in_byte      (s_axis_tdata),
		.end_of_input (s_axis_tlast),
		.start_of_file(s_axis_tuser),
		.key_bytes    (key_bytes_q),
		.key_length   (key_length_q),
		.push         (q_push),
		.cmd          (wr_cmd)
	);

	kb64_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_cmd(wr_cmd),
		.pop   (q_pop),
		.rd_cmd(rd_cmd),
		.valid (q_valid),
		.full  (q_full)
	);

	kb64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (rd_cmd),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_is_end(m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// an end marker is a single zero item
	`KB64_ASSERT_NOW(a_end_marker, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'd0), "end marker not single zero item")
	// the front never writes into a full queue
	`KB64_ASSERT_NOW(a_no_overflow, q_push, !q_full, "push into full queue")
	// output drains once the last item leaves with nothing queued
	`KB64_ASSERT_NEXT(a_drain, m_axis_tvalid && m_axis_tready && m_axis_tlast && !q_valid, !m_axis_tvalid, "output valid without queued work")

endmodule

FILE: rtl/kb64_front.sv
`timescale 1ns / 1ps

module kb64_front
	import kb64_pkg::*;
#(
	parameter int MAX_KEY_LENGTH = MAX_KEY_LENGTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              in_byte,
	input  logic                    end_of_input,
	input  logic                    start_of_file,
	input  logic [KEY_BYTES_W-1:0]  key_bytes,
	input  logic [KEY_LENGTH_W-1:0] key_length,
	output logic                    push,
	output kb64_cmd_t               cmd
);

	localparam int PosW = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1;
	localparam int LenW = $clog2(MAX_KEY_LENGTH + 1);

	localparam logic [2:0] PH_KEY    = 3'd0;
	localparam logic [2:0] PH_DROP   = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_DECODE = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [2:0]      phase_q, phase_d, ph;
	logic [PosW-1:0] pos_q, pos_d, pos;
	logic [17:0]     grp_q, grp_d, grp;
	logic [1:0]      cnt_q, cnt_d, cnt;
	logic [LenW-1:0] len_eff, pos_inc;
	logic [7:0]      key_char;
	logic [6:0]      sym;

	// clamp key length into 1..MAX_KEY_LENGTH
	always_comb begin
		if (key_length == '0) begin
			len_eff = LenW'(1);
		end else if (key_length > KEY_LENGTH_W'(MAX_KEY_LENGTH)) begin
			len_eff = LenW'(MAX_KEY_LENGTH);
		end else begin
			len_eff = key_length[LenW-1:0];
		end
	end

	// start of file clears state before the item is handled
	assign ph  = start_of_file ? PH_KEY : phase_q;
	assign pos = start_of_file ? '0 : pos_q;
	assign grp = start_of_file ? '0 : grp_q;
	assign cnt = start_of_file ? '0 : cnt_q;

	assign key_char = key_bytes[8*pos +: 8];
	assign pos_inc  = LenW'(pos) + LenW'(1);
	assign sym      = sym_decode(in_byte);

	// classify the item and work out the next state
	always_comb begin
		phase_d   = ph;
		pos_d     = pos;
		grp_d     = grp;
		cnt_d     = cnt;
		push      = 1'b0;
		cmd       = '0;
		if (!accept) begin
			phase_d = phase_q;
			pos_d   = pos_q;
			grp_d   = grp_q;
			cnt_d   = cnt_q;
		end else if (ph == PH_DONE) begin
			phase_d = PH_DONE;
		end else if (end_of_input) begin
			push       = 1'b1;
			cmd.is_end = 1'b1;
			phase_d    = PH_DONE;
		end else begin
			case (ph)
				PH_KEY: begin
					if (in_byte != key_char) begin
						pos_d = '0;
					end else if (pos_inc >= len_eff) begin
						pos_d   = '0;
						phase_d = PH_DROP;
					end else begin
						pos_d = PosW'(pos_inc);
					end
				end
				PH_DROP: begin
					phase_d = PH_SKIP;
				end
				PH_SKIP: begin
					if (in_byte == CHAR_QUOTE) phase_d = PH_DECODE;
				end
				PH_DECODE: begin
					if (!sym[6]) begin
						push       = 1'b1;
						cmd.is_end = 1'b1;
						phase_d    = PH_DONE;
					end else if (cnt != 2'd3) begin
						grp_d = {grp[11:0], sym[5:0]};
						cnt_d = cnt + 2'd1;
					end else begin
						push      = 1'b1;
						cmd.group = {grp, sym[5:0]};
						grp_d     = '0;
						cnt_d     = '0;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			pos_q   <= '0;
			grp_q   <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			grp_q   <= grp_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: rtl/kb64_fifo.sv
`timescale 1ns / 1ps

module kb64_fifo
	import kb64_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  kb64_cmd_t wr_cmd,
	input  logic      pop,
	output kb64_cmd_t rd_cmd,
	output logic      valid,
	output logic      full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	kb64_cmd_t      mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign valid  = (count_q != '0);
	assign full   = (count_q == CW'(DEPTH));
	assign rd_cmd = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/kb64_back.sv
`timescale 1ns / 1ps

module kb64_back
	import kb64_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  kb64_cmd_t q_cmd,
	input  logic      q_valid,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output logic [7:0] out_byte,
	output logic      out_is_end,
	output logic      out_last
);

	kb64_cmd_t  cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       done;

	assign out_valid  = busy_q;
	assign out_is_end = cur_q.is_end;
	assign out_last   = cur_q.is_end || (idx_q == 2'd2);

	// most significant byte of the group first
	always_comb begin
		case (idx_q)
			2'd0:    out_byte = cur_q.group[23:16];
			2'd1:    out_byte = cur_q.group[15:8];
			2'd2:    out_byte = cur_q.group[7:0];
			default: out_byte = 8'd0;
		endcase
	end

	assign done  = busy_q && out_ready && out_last;
	assign q_pop = q_valid && (!busy_q || done);

	// load the next entry or step through the bytes of the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_cmd;
	end

endmodule
